### src/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared constants, types and helpers for the packet threat tracker.
// ----------------------------------------------------------------------------
package ptt_pkg;

  // table geometry
  localparam int unsigned SOURCE_ENTRIES   = 64;
  localparam int unsigned PORTS_PER_SOURCE = 32;
  localparam int unsigned ENT_W   = $clog2(SOURCE_ENTRIES);
  localparam int unsigned PIDX_W  = $clog2(PORTS_PER_SOURCE);
  localparam int unsigned PTOT_W  = $clog2(PORTS_PER_SOURCE + 1);
  localparam int unsigned PADDR_W = $clog2(SOURCE_ENTRIES * PORTS_PER_SOURCE);

  // field widths
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned PORT_W   = 16;
  localparam int unsigned KEY_W    = ADDR_W + 1;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned THR_W    = 6;
  localparam int unsigned LIMIT_W  = 16;
  localparam int unsigned DPORTS_W = 6;
  localparam int unsigned ALERT_W  = 2;
  localparam int unsigned IN_W     = 56;
  localparam int unsigned OUT_W    = 272;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // reset values of the registers
  localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(15);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(50);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_THR  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ICMP_LIMIT = 1'b1;

  // protocol codes
  localparam logic [KIND_W-1:0] KIND_TCP  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_UDP  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ICMP = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ARP  = 3'd3;

  // alert codes
  localparam logic [ALERT_W-1:0] ALERT_NONE  = 2'd0;
  localparam logic [ALERT_W-1:0] ALERT_SCAN  = 2'd1;
  localparam logic [ALERT_W-1:0] ALERT_FLOOD = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KEY_RD,
    ST_KEY_CMP,
    ST_ENTRY,
    ST_PORT_RD,
    ST_PORT_CMP,
    ST_PORT_DECIDE,
    ST_WRITE,
    ST_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic idx_inc;
    logic key_cmp;
    logic take_hit;
    logic take_alloc;
    logic set_full;
    logic entry_upd;
    logic pidx_clr;
    logic pidx_inc;
    logic port_rd;
    logic port_hit;
    logic port_commit;
    logic rec_write;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_lookup;
    logic idx_last;
    logic key_hit;
    logic free_any;
    logic port_track;
    logic ptot_zero;
    logic port_match;
    logic pidx_last;
    logic out_busy;
  } sts_t;

  // one source table record
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [CNT_W-1:0]  pkts;
    logic [CNT_W-1:0]  icmp;
    logic [PTOT_W-1:0] ptot;
  } rec_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == '1) ? v : v + CNT_W'(1);
  endfunction

endpackage

### src/ptt_ctrl.sv
// ----------------------------------------------------------------------------
// ptt_ctrl
// Sequencer: source search, port-set search, write-back and result hand-off.
// ----------------------------------------------------------------------------
module ptt_ctrl import ptt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_KEY_RD;
        end
      end
      ST_KEY_RD: begin
        // nothing to look up for sourceless non-icmp packets
        if (sts.need_lookup) begin
          state_next = ST_KEY_CMP;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_KEY_CMP: begin
        cmd.key_cmp = 1'b1;
        if (sts.key_hit) begin
          cmd.take_hit = 1'b1;
          state_next   = ST_ENTRY;
        end else if (sts.idx_last) begin
          if (sts.free_any) begin
            cmd.take_alloc = 1'b1;
            state_next     = ST_ENTRY;
          end else begin
            cmd.set_full = 1'b1;
            state_next   = ST_FINISH;
          end
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = ST_KEY_RD;
        end
      end
      ST_ENTRY: begin
        cmd.entry_upd = 1'b1;
        cmd.pidx_clr  = 1'b1;
        if (!sts.port_track) begin
          state_next = ST_WRITE;
        end else if (sts.ptot_zero) begin
          state_next = ST_PORT_DECIDE;
        end else begin
          state_next = ST_PORT_RD;
        end
      end
      ST_PORT_RD: begin
        cmd.port_rd = 1'b1;
        state_next  = ST_PORT_CMP;
      end
      ST_PORT_CMP: begin
        if (sts.port_match) begin
          cmd.port_hit = 1'b1;
          state_next   = ST_PORT_DECIDE;
        end else if (sts.pidx_last) begin
          state_next = ST_PORT_DECIDE;
        end else begin
          cmd.pidx_inc = 1'b1;
          state_next   = ST_PORT_RD;
        end
      end
      ST_PORT_DECIDE: begin
        cmd.port_commit = 1'b1;
        state_next      = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.rec_write = 1'b1;
        state_next    = ST_FINISH;
      end
      ST_FINISH: begin
        // wait for the output register to drain
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### src/ptt_datapath.sv
// ----------------------------------------------------------------------------
// ptt_datapath
// Source table, port-set memory, global counters, registers and result beat.
// ----------------------------------------------------------------------------
module ptt_datapath import ptt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic [IN_W-1:0]       s_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_W-1:0]      m_tdata
);

  // registers
  logic [THR_W-1:0]   scan_thr;
  logic [LIMIT_W-1:0] icmp_limit;

  // captured item
  logic [KIND_W-1:0] kind;
  logic              present;
  logic [ADDR_W-1:0] addr;
  logic [PORT_W-1:0] port;
  logic              susp_in;

  // table storage
  logic [SOURCE_ENTRIES-1:0] valid;
  rec_t                      rec_mem [SOURCE_ENTRIES];
  logic [PORT_W-1:0]         port_mem [SOURCE_ENTRIES * PORTS_PER_SOURCE];
  rec_t                      rec_q;
  logic [PORT_W-1:0]         port_q;

  // search and working state
  logic [ENT_W-1:0]  idx;
  logic              free_valid;
  logic [ENT_W-1:0]  free_idx;
  logic [ENT_W-1:0]  ent;
  logic              have_entry;
  logic [CNT_W-1:0]  cur_pkts;
  logic [CNT_W-1:0]  cur_icmp;
  logic [PTOT_W-1:0] cur_ptot;
  logic [PIDX_W-1:0] pidx;
  logic              port_found;
  logic              full;

  // global counters
  logic [CNT_W-1:0] count_total, count_tcp, count_udp, count_icmp;
  logic [CNT_W-1:0] count_arp, count_other, count_alerts;

  logic [KEY_W-1:0]   key;
  logic [PADDR_W-1:0] port_base;
  logic [PADDR_W-1:0] port_rd_addr;
  logic [PADDR_W-1:0] port_wr_addr;
  logic               is_tcp_udp;
  logic               scan_hit;
  logic               flood_hit;
  logic               susp_final;
  logic [ALERT_W-1:0] alert;
  logic [DPORTS_W-1:0] dports;
  logic [CNT_W-1:0]   spkts;

  assign key          = present ? {1'b1, addr} : '0;
  assign is_tcp_udp   = (kind == KIND_TCP) || (kind == KIND_UDP);
  assign port_base    = PADDR_W'(ent) * PADDR_W'(PORTS_PER_SOURCE);
  assign port_rd_addr = port_base + PADDR_W'(pidx);
  assign port_wr_addr = port_base + PADDR_W'(cur_ptot);

  // status towards the controller
  always_comb begin
    sts.need_lookup = present || (kind == KIND_ICMP);
    sts.idx_last    = (idx == ENT_W'(SOURCE_ENTRIES - 1));
    sts.key_hit     = valid[idx] && (rec_q.key == key);
    sts.free_any    = free_valid || !valid[idx];
    sts.port_track  = is_tcp_udp && present && (port != '0);
    sts.ptot_zero   = (cur_ptot == '0);
    sts.port_match  = (port_q == port);
    sts.pidx_last   = (PTOT_W'(pidx) == cur_ptot - PTOT_W'(1));
    sts.out_busy    = m_tvalid && !m_tready;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_thr   <= THR_RESET;
      icmp_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCAN_THR:   scan_thr   <= cfg_data[THR_W-1:0];
        CFG_ICMP_LIMIT: icmp_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind    <= s_tdata[2:0];
      present <= s_tdata[3];
      addr    <= s_tdata[35:4];
      port    <= s_tdata[51:36];
      susp_in <= s_tdata[52];
    end
  end

  // source record memory, one read per search step
  always_ff @(posedge clk) begin
    rec_q <= rec_mem[idx];
    if (cmd.rec_write) begin
      rec_mem[ent] <= '{key: key, pkts: cur_pkts, icmp: cur_icmp, ptot: cur_ptot};
    end
  end

  // port-set memory
  always_ff @(posedge clk) begin
    if (cmd.port_rd) begin
      port_q <= port_mem[port_rd_addr];
    end
    if (cmd.port_commit && !port_found && (cur_ptot < PTOT_W'(PORTS_PER_SOURCE))) begin
      port_mem[port_wr_addr] <= port;
    end
  end

  // entry valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.take_alloc) begin
      valid[free_valid ? free_idx : idx] <= 1'b1;
    end
  end

  // search and per-entry working state
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx        <= '0;
      free_valid <= 1'b0;
      have_entry <= 1'b0;
      full       <= 1'b0;
      port_found <= 1'b0;
    end else begin
      if (cmd.idx_inc) begin
        idx <= idx + ENT_W'(1);
      end
      // remember the lowest free slot seen
      if (cmd.key_cmp && !valid[idx] && !free_valid) begin
        free_valid <= 1'b1;
        free_idx   <= idx;
      end
      if (cmd.take_hit) begin
        ent        <= idx;
        have_entry <= 1'b1;
        cur_pkts   <= rec_q.pkts;
        cur_icmp   <= rec_q.icmp;
        cur_ptot   <= rec_q.ptot;
      end
      if (cmd.take_alloc) begin
        ent        <= free_valid ? free_idx : idx;
        have_entry <= 1'b1;
        cur_pkts   <= '0;
        cur_icmp   <= '0;
        cur_ptot   <= '0;
      end
      if (cmd.set_full) begin
        full <= 1'b1;
      end
      if (cmd.entry_upd) begin
        if (present) begin
          cur_pkts <= sat_inc(cur_pkts);
        end
        if (kind == KIND_ICMP) begin
          cur_icmp <= sat_inc(cur_icmp);
        end
      end
      if (cmd.pidx_clr) begin
        pidx <= '0;
      end else if (cmd.pidx_inc) begin
        pidx <= pidx + PIDX_W'(1);
      end
      if (cmd.port_hit) begin
        port_found <= 1'b1;
      end
      // append a new port or flag a full set
      if (cmd.port_commit && !port_found) begin
        if (cur_ptot < PTOT_W'(PORTS_PER_SOURCE)) begin
          cur_ptot <= cur_ptot + PTOT_W'(1);
        end else begin
          full <= 1'b1;
        end
      end
    end
  end

  // alert decision from the finished entry state
  always_comb begin
    scan_hit   = have_entry && sts.port_track && (32'(cur_ptot) >= 32'(scan_thr));
    flood_hit  = have_entry && (kind == KIND_ICMP) && (cur_icmp > CNT_W'(icmp_limit));
    susp_final = susp_in || scan_hit || flood_hit;
    if (flood_hit) begin
      alert = ALERT_FLOOD;
    end else if (scan_hit) begin
      alert = ALERT_SCAN;
    end else begin
      alert = ALERT_NONE;
    end
    if (!have_entry) begin
      dports = '0;
    end else if (32'(cur_ptot) > 32'((1 << DPORTS_W) - 1)) begin
      dports = '1;
    end else begin
      dports = DPORTS_W'(cur_ptot);
    end
    spkts = have_entry ? cur_pkts : '0;
  end

  // global counters
  always_ff @(posedge clk) begin
    if (rst) begin
      count_total  <= '0;
      count_tcp    <= '0;
      count_udp    <= '0;
      count_icmp   <= '0;
      count_arp    <= '0;
      count_other  <= '0;
      count_alerts <= '0;
    end else if (cmd.finish) begin
      count_total <= sat_inc(count_total);
      case (kind)
        KIND_TCP:  count_tcp   <= sat_inc(count_tcp);
        KIND_UDP:  count_udp   <= sat_inc(count_udp);
        KIND_ICMP: count_icmp  <= sat_inc(count_icmp);
        KIND_ARP:  count_arp   <= sat_inc(count_arp);
        default:   count_other <= sat_inc(count_other);
      endcase
      if (susp_final) begin
        count_alerts <= sat_inc(count_alerts);
      end
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // counters are sampled after this item's increment
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      m_tdata[0]       <= susp_final;
      m_tdata[2:1]     <= alert;
      m_tdata[8:3]     <= dports;
      m_tdata[40:9]    <= spkts;
      m_tdata[72:41]   <= sat_inc(count_total);
      m_tdata[104:73]  <= (kind == KIND_TCP)  ? sat_inc(count_tcp)  : count_tcp;
      m_tdata[136:105] <= (kind == KIND_UDP)  ? sat_inc(count_udp)  : count_udp;
      m_tdata[168:137] <= (kind == KIND_ICMP) ? sat_inc(count_icmp) : count_icmp;
      m_tdata[200:169] <= (kind == KIND_ARP)  ? sat_inc(count_arp)  : count_arp;
      m_tdata[232:201] <= (kind > KIND_ARP)   ? sat_inc(count_other) : count_other;
      m_tdata[264:233] <= susp_final ? sat_inc(count_alerts) : count_alerts;
      m_tdata[265]     <= full;
      m_tdata[OUT_W-1:266] <= '0;
    end
  end

endmodule

### src/packet_threat_tracker_top.sv
// ----------------------------------------------------------------------------
// packet_threat_tracker_top
// Port-scan and ICMP-flood tracker over a table of source addresses.
// ----------------------------------------------------------------------------
// Sequence: a source lookup searches the table entry by entry (up to 64, ending
// at a hit) or flags a full table, updates the entry, compares a tracked port
// against each stored port and writes back; without a lookup, straight to result.
// Flow: one header at a time, the next beat taken once the result is
// registered; the hand-off waits while an earlier result beat is stalled.
// Reset (rst, synchronous): counters cleared, entries invalid, registers reset.
// ----------------------------------------------------------------------------
module packet_threat_tracker_top import ptt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // protocol_kind, source_present, source_address, destination_port,
  // already_suspicious
  input  logic [IN_W-1:0]       s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // suspicious, alert_kind, distinct_ports, source_packets, total_count,
  // tcp_count, udp_count, icmp_total, arp_count, other_count, alert_count,
  // table_full
  output logic [OUT_W-1:0]      m_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  ptt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ptt_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tdata   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

### src/ptt_checker.sv
// ----------------------------------------------------------------------------
// ptt_checker
// Port-level checks on the tracker, bound to the top level.
// ----------------------------------------------------------------------------
module ptt_checker import ptt_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              s_tvalid,
  input logic              s_tready,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [OUT_W-1:0]  m_tdata
);

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // one header in flight: no second beat taken right after one
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a header is in flight");

  // no result is pending after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result pending after reset");

  // any alert marks the packet suspicious
  a_alert_susp: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[2:1] != ALERT_NONE) |-> m_tdata[0])
    else $error("alert without suspicion");

  // alert code stays within its defined set
  a_alert_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:1] == ALERT_NONE) || (m_tdata[2:1] == ALERT_SCAN)
                 || (m_tdata[2:1] == ALERT_FLOOD))
    else $error("undefined alert code");

endmodule

bind packet_threat_tracker_top ptt_checker u_ptt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### tb/sv/packet_threat_tracker_top_tb.sv
// ----------------------------------------------------------------------------
// packet_threat_tracker_top_tb
// Self-checking bench for the packet threat tracker. Header beats are queued
// by the sequence block, sent by a clocked driver and scored against an
// in-bench tracker model. Phases change the scan threshold and flood limit.
// Stalls are applied on both stream sides.
// ----------------------------------------------------------------------------
module packet_threat_tracker_top_tb;
  import ptt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]        pad;
    logic              susp;
    logic [PORT_W-1:0] port;
    logic [ADDR_W-1:0] addr;
    logic              present;
    logic [KIND_W-1:0] kind;
  } hdr_t;

  typedef struct packed {
    logic [5:0]          pad;
    logic                full;
    logic [CNT_W-1:0]    alerts;
    logic [CNT_W-1:0]    other;
    logic [CNT_W-1:0]    arp;
    logic [CNT_W-1:0]    icmp;
    logic [CNT_W-1:0]    udp;
    logic [CNT_W-1:0]    tcp;
    logic [CNT_W-1:0]    total;
    logic [CNT_W-1:0]    spkts;
    logic [DPORTS_W-1:0] dports;
    logic [ALERT_W-1:0]  alert;
    logic                susp;
  } verdict_t;

  typedef enum int {IDLE_SEND_HEAVY, IDLE_RECV_HEAVY, IDLE_NONE} idle_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  packet_threat_tracker_top dut (.*);

  always #6 clk = ~clk;

  hdr_t       pending_hdrs[$];
  verdict_t   expected_verdicts[$];
  idle_mode_t idle_mode = IDLE_SEND_HEAVY;
  int         fail_count = 0;
  int         seen_scan = 0, seen_flood = 0, seen_full = 0, beats_sent = 0;

  // tracker model state
  logic [THR_W-1:0]   mdl_thr;
  logic [LIMIT_W-1:0] mdl_limit;
  logic               tbl_valid[SOURCE_ENTRIES];
  logic [KEY_W-1:0]   tbl_key[SOURCE_ENTRIES];
  logic [CNT_W-1:0]   tbl_pkts[SOURCE_ENTRIES];
  logic [CNT_W-1:0]   tbl_icmp[SOURCE_ENTRIES];
  int                 tbl_ptot[SOURCE_ENTRIES];
  logic [PORT_W-1:0]  tbl_ports[SOURCE_ENTRIES][PORTS_PER_SOURCE];
  logic [CNT_W-1:0]   g_total, g_tcp, g_udp, g_icmp, g_arp, g_other, g_alerts;

  // source pool for random traffic, more than the table holds
  logic [ADDR_W-1:0]  src_pool[80];

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1;
  endfunction

  function automatic verdict_t track_header(input hdr_t h);
    verdict_t r;
    int e, n, j;
    logic found, tcp_udp;
    logic [KEY_W-1:0] key;
    r = '0;
    r.susp = h.susp;
    e = -1;
    tcp_udp = (h.kind == KIND_TCP) || (h.kind == KIND_UDP);
    g_total = bump(g_total);
    case (h.kind)
      KIND_TCP:  g_tcp  = bump(g_tcp);
      KIND_UDP:  g_udp  = bump(g_udp);
      KIND_ICMP: g_icmp = bump(g_icmp);
      KIND_ARP:  g_arp  = bump(g_arp);
      default:   g_other = bump(g_other);
    endcase
    // lookup or lowest free slot
    if (h.present || h.kind == KIND_ICMP) begin
      key = h.present ? {1'b1, h.addr} : '0;
      for (int i = 0; i < SOURCE_ENTRIES; i++)
        if (e < 0 && tbl_valid[i] && tbl_key[i] == key) e = i;
      if (e < 0)
        for (int i = 0; i < SOURCE_ENTRIES; i++)
          if (e < 0 && !tbl_valid[i]) begin
            e = i;
            tbl_valid[i] = 1'b1;
            tbl_key[i] = key;
            tbl_pkts[i] = '0;
            tbl_icmp[i] = '0;
            tbl_ptot[i] = 0;
          end
      if (e < 0) r.full = 1'b1;
    end
    if (e >= 0) begin
      if (h.present) tbl_pkts[e] = bump(tbl_pkts[e]);
      if (tcp_udp && h.present && h.port != 0) begin
        n = tbl_ptot[e];
        found = 1'b0;
        for (j = 0; j < n; j++)
          if (tbl_ports[e][j] == h.port) found = 1'b1;
        if (!found) begin
          if (n < PORTS_PER_SOURCE) begin
            tbl_ports[e][n] = h.port;
            n++;
            tbl_ptot[e] = n;
          end else r.full = 1'b1;
        end
        if (n >= mdl_thr) begin
          r.susp = 1'b1;
          r.alert = ALERT_SCAN;
        end
      end
      if (h.kind == KIND_ICMP) begin
        tbl_icmp[e] = bump(tbl_icmp[e]);
        if (tbl_icmp[e] > mdl_limit) begin
          r.susp = 1'b1;
          r.alert = ALERT_FLOOD;
        end
      end
      r.dports = (tbl_ptot[e] > 63) ? 6'd63 : DPORTS_W'(tbl_ptot[e]);
      r.spkts = tbl_pkts[e];
    end
    if (r.susp) g_alerts = bump(g_alerts);
    r.total = g_total; r.tcp = g_tcp; r.udp = g_udp; r.icmp = g_icmp;
    r.arp = g_arp; r.other = g_other; r.alerts = g_alerts;
    return r;
  endfunction

  function automatic hdr_t mk_hdr(input logic [2:0] kind, input logic pres,
                                  input logic [31:0] addr, input logic [15:0] port,
                                  input logic susp);
    hdr_t h;
    h = '0;
    h.kind = kind; h.present = pres; h.addr = addr; h.port = port; h.susp = susp;
    return h;
  endfunction

  function automatic hdr_t rand_hdr();
    hdr_t h;
    int k, p;
    h = '0;
    k = $urandom_range(0, 99);
    if (k < 45) h.kind = KIND_W'($urandom_range(0, 1));
    else if (k < 72) h.kind = KIND_ICMP;
    else h.kind = KIND_W'($urandom_range(3, 7));
    h.present = ($urandom_range(0, 9) != 0);
    // mostly a few hot sources, sometimes any of the pool
    h.addr = ($urandom_range(0, 9) < 6) ? src_pool[$urandom_range(0, 7)]
                                        : src_pool[$urandom_range(0, 79)];
    if (!h.present && $urandom_range(0, 1)) h.addr = $urandom;
    p = $urandom_range(0, 99);
    if (p < 60) h.port = PORT_W'($urandom_range(1, 40));
    else if (p < 70) h.port = '0;
    else h.port = PORT_W'($urandom);
    h.susp = ($urandom_range(0, 9) == 0);
    return h;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_SCAN_THR) mdl_thr = val[THR_W-1:0];
    else mdl_limit = val[LIMIT_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_hdrs.size() != 0 || s_tvalid || expected_verdicts.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // driver: predict on acceptance, then present the next beat or idle
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_verdicts.push_back(track_header(hdr_t'(s_tdata)));
        beats_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_hdrs.size() != 0 &&
            !(idle_mode == IDLE_SEND_HEAVY && $urandom_range(0, 99) < 31) &&
            !(idle_mode == IDLE_RECV_HEAVY && $urandom_range(0, 99) < 47)) begin
          s_tvalid <= 1'b1;
          s_tdata <= pending_hdrs.pop_front();
        end else s_tvalid <= 1'b0;
      end
    end
  end

  // monitor: random back-pressure and field compare
  always @(posedge clk) begin
    verdict_t got, want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = verdict_t'(m_tdata);
        if (expected_verdicts.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count++;
        end else begin
          want = expected_verdicts.pop_front();
          check_field("suspicious", want.susp, got.susp);
          check_field("alert_kind", want.alert, got.alert);
          check_field("distinct_ports", want.dports, got.dports);
          check_field("source_packets", want.spkts, got.spkts);
          check_field("total_count", want.total, got.total);
          check_field("tcp_count", want.tcp, got.tcp);
          check_field("udp_count", want.udp, got.udp);
          check_field("icmp_total", want.icmp, got.icmp);
          check_field("arp_count", want.arp, got.arp);
          check_field("other_count", want.other, got.other);
          check_field("alert_count", want.alerts, got.alerts);
          check_field("table_full", want.full, got.full);
          if (want.alert == ALERT_SCAN) seen_scan++;
          if (want.alert == ALERT_FLOOD) seen_flood++;
          if (want.full) seen_full++;
        end
      end
      case (idle_mode)
        IDLE_SEND_HEAVY: m_tready <= ($urandom_range(0, 99) >= 47);
        IDLE_RECV_HEAVY: m_tready <= ($urandom_range(0, 99) >= 31);
        default:         m_tready <= 1'b1;
      endcase
    end
  end

  // sequence
  initial begin
    mdl_thr = THR_RESET;
    mdl_limit = LIMIT_RESET;
    g_total = '0; g_tcp = '0; g_udp = '0; g_icmp = '0;
    g_arp = '0; g_other = '0; g_alerts = '0;
    for (int i = 0; i < SOURCE_ENTRIES; i++) tbl_valid[i] = 1'b0;
    src_pool[0] = '0;
    src_pool[1] = '1;
    for (int i = 2; i < 80; i++) src_pool[i] = $urandom;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: every protocol, absent source, port and address extremes
    for (int k = 0; k < 8; k++)
      pending_hdrs.push_back(mk_hdr(3'(k), 1'b0, '1, 16'd80, 1'b0));
    pending_hdrs.push_back(mk_hdr(KIND_ICMP, 1'b0, 32'h0, 16'd0, 1'b1));
    pending_hdrs.push_back(mk_hdr(KIND_TCP, 1'b1, 32'h0, 16'd0, 1'b0));
    pending_hdrs.push_back(mk_hdr(KIND_TCP, 1'b1, 32'h0, 16'hFFFF, 1'b0));
    pending_hdrs.push_back(mk_hdr(KIND_UDP, 1'b1, 32'h0, 16'hFFFF, 1'b1));
    pending_hdrs.push_back(mk_hdr(KIND_UDP, 1'b1, '1, 16'd1, 1'b0));
    pending_hdrs.push_back(mk_hdr(KIND_ICMP, 1'b1, '1, 16'd7, 1'b0));
    pending_hdrs.push_back(mk_hdr(KIND_ARP, 1'b1, '1, 16'd22, 1'b1));
    pending_hdrs.push_back(mk_hdr(3'd7, 1'b1, 32'h0, 16'd443, 1'b0));
    for (int i = 0; i < 60; i++) pending_hdrs.push_back(rand_hdr());
    drain();

    // threshold and limit at their low ends, pause until idle first
    write_reg(CFG_SCAN_THR, 16'd1);
    write_reg(CFG_ICMP_LIMIT, 16'd0);
    for (int i = 0; i < 70; i++) pending_hdrs.push_back(rand_hdr());
    drain();

    idle_mode = IDLE_RECV_HEAVY;
    // upper extremes; fill the table with fresh sources
    write_reg(CFG_SCAN_THR, 16'd32);
    write_reg(CFG_ICMP_LIMIT, 16'hFFFF);
    for (int i = 0; i < 70; i++) pending_hdrs.push_back(
      mk_hdr(KIND_W'($urandom_range(0, 2)), 1'b1, src_pool[i],
             PORT_W'($urandom_range(1, 20)), 1'b0));
    drain();

    // threshold outside range, small flood limit; hammer one source's port set
    write_reg(CFG_SCAN_THR, 16'd0);
    write_reg(CFG_ICMP_LIMIT, 16'd3);
    for (int i = 0; i < 45; i++)
      pending_hdrs.push_back(mk_hdr(KIND_TCP, 1'b1, src_pool[0], 16'(1000 + i), 1'b0));
    for (int i = 0; i < 40; i++) pending_hdrs.push_back(rand_hdr());
    drain();

    idle_mode = IDLE_NONE;
    write_reg(CFG_SCAN_THR, 16'd63);
    write_reg(CFG_ICMP_LIMIT, 16'd50);
    for (int i = 0; i < 50; i++) pending_hdrs.push_back(rand_hdr());
    drain();

    write_reg(CFG_SCAN_THR, 16'd15);
    for (int i = 0; i < 50; i++) pending_hdrs.push_back(rand_hdr());
    drain();
    repeat (220) @(posedge clk);

    $display("%0d headers checked; scan alerts %0d, flood alerts %0d, table full %0d",
             beats_sent, seen_scan, seen_flood, seen_full);
    $display("register settings covered threshold 0/1/15/32/63, limit 0/3/50/65535");
    if (fail_count == 0 && expected_verdicts.size() == 0)
      $display("packet_threat_tracker_top: match");
    else
      $display("packet_threat_tracker_top: mismatch");
    $finish;
  end

  // watchdog
  initial begin
    #(12 * 1000000);
    $display("packet_threat_tracker_top: mismatch");
    $finish;
  end

endmodule
